// File: src/grm_pkg.sv
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types and constants for the grayscale row mirror.
// ----------------------------------------------------------------------------
package grm_pkg;

	localparam int PIX_W          = 8;
	localparam int RW_W           = 13;
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int ROW_WIDTH_RST  = 640;
	localparam int BUF_DEPTH      = 3;
	localparam int BUF_PTR_W      = 2;
	localparam int BUF_CNT_W      = 2;
	localparam int LUMA_W         = 16;

	// Luma weights 0.21, 0.72 and 0.07 in unsigned Q0.8.
	localparam logic [LUMA_W-1:0] LUMA_WR = 16'd54;
	localparam logic [LUMA_W-1:0] LUMA_WG = 16'd184;
	localparam logic [LUMA_W-1:0] LUMA_WB = 16'd18;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	typedef struct packed {
		logic             gray_valid;
		logic [PIX_W-1:0] gray_value;
		logic             mirror_valid;
		logic [PIX_W-1:0] mirror_value;
		logic             mirror_row_end;
	} res_t;

endpackage

// File: src/grm_row_core.sv
// ----------------------------------------------------------------------------
// grm_row_core
// Luma, ping-pong line store, row tracking and the first result stage.
// ----------------------------------------------------------------------------
module grm_row_core #(
	parameter int MAX_WIDTH = grm_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [grm_pkg::RW_W-1:0]   cfg_wdata,
	input  logic                       in_valid,
	input  logic                       space,
	input  logic                       cmd,
	input  logic [grm_pkg::PIX_W-1:0]  red,
	input  logic [grm_pkg::PIX_W-1:0]  green,
	input  logic [grm_pkg::PIX_W-1:0]  blue,
	output logic                       res_valid,
	output grm_pkg::res_t              res
);
	import grm_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (WW > RW_W) ? WW : RW_W;
	localparam int AW   = CW + 1;

	logic [RW_W-1:0]   row_width_q;
	logic [CW-1:0]     col_q;
	logic              bank_q;
	logic              prev_q;

	logic [7:0]        mem [2**AW];

	logic              acc;
	logic              is_pixel;
	logic [CMPW-1:0]   rw_ext;
	logic [WW-1:0]     w_eff;
	logic [WW-1:0]     col_ext;
	logic [WW-1:0]     col_inc;
	logic              last;
	logic [WW-1:0]     mcol_full;
	logic [CW-1:0]     mcol;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [LUMA_W-1:0] luma_sum;
	logic [PIX_W-1:0]  gray;

	logic              v_s1;
	logic              gv_s1;
	logic [PIX_W-1:0]  gray_s1;
	logic              mv_s1;
	logic              mend_s1;
	logic [PIX_W-1:0]  rd_s1;

	assign acc      = in_valid & space;
	assign is_pixel = (cmd == CMD_PIXEL);

	assign rw_ext = CMPW'(row_width_q);

	always_comb begin
		if (rw_ext == '0) begin
			w_eff = WW'(1);
		end else if (rw_ext > CMPW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = rw_ext[WW-1:0];
		end
	end

	assign col_ext = WW'(col_q);
	assign col_inc = col_ext + WW'(1);
	assign last    = (col_inc >= w_eff);

	assign mcol_full = (col_ext < w_eff) ? (w_eff - WW'(1) - col_ext) : '0;
	assign mcol      = mcol_full[CW-1:0];

	assign waddr = {bank_q, col_q};
	assign raddr = {~bank_q, mcol};

	assign luma_sum = LUMA_WR * LUMA_W'(red) + LUMA_WG * LUMA_W'(green)
		+ LUMA_WB * LUMA_W'(blue);
	assign gray = luma_sum[LUMA_W-1:LUMA_W-PIX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= RW_W'(ROW_WIDTH_RST);
		end else if (cfg_wen) begin
			row_width_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			bank_q <= 1'b0;
			prev_q <= 1'b0;
		end else if (acc) begin
			if (last) begin
				col_q <= '0;
				if (is_pixel) begin
					bank_q <= ~bank_q;
					prev_q <= 1'b1;
				end else begin
					prev_q <= 1'b0;
				end
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_pixel) begin
			mem[waddr] <= gray;
		end
		if (acc) begin
			rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			gv_s1   <= is_pixel;
			gray_s1 <= is_pixel ? gray : '0;
			mv_s1   <= prev_q;
			mend_s1 <= prev_q & last;
		end
	end

	assign res_valid          = v_s1;
	assign res.gray_valid     = gv_s1;
	assign res.gray_value     = gray_s1;
	assign res.mirror_valid   = mv_s1;
	assign res.mirror_value   = mv_s1 ? rd_s1 : '0;
	assign res.mirror_row_end = mend_s1;

`ifndef NO_ASSERTIONS
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(AW'(col_q) < AW'(MAX_WIDTH)))
		else $error("column counter beyond line store width");

	a_pixel_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_pixel && last) |=> (prev_q && col_q == '0))
		else $error("pixel row end did not arm the mirrored row");

	a_end_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && mend_s1) |-> mv_s1)
		else $error("row end flagged without a mirrored pixel");
`endif

endmodule

// File: src/grm_out_buf.sv
// ----------------------------------------------------------------------------
// grm_out_buf
// Three-entry result buffer that decouples the output stall from the input.
// ----------------------------------------------------------------------------
module grm_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	input  grm_pkg::res_t  wr_data,
	output logic           space,
	output logic           out_valid,
	input  logic           out_ready,
	output grm_pkg::res_t  out_data
);
	import grm_pkg::*;

	res_t                 ent_q [BUF_DEPTH];
	logic [BUF_PTR_W-1:0] wptr_q;
	logic [BUF_PTR_W-1:0] rptr_q;
	logic [BUF_CNT_W-1:0] cnt_q;
	logic                 pop;
	logic [BUF_CNT_W:0]   fill;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & out_ready;
	assign out_data  = ent_q[rptr_q];

	// An item accepted now passes the core's first result stage before it lands
	// in the buffer; count the one already on its way.
	assign fill  = (BUF_CNT_W+1)'(cnt_q) + (BUF_CNT_W+1)'(wr_valid);
	assign space = (fill < (BUF_CNT_W+1)'(BUF_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_valid) begin
			ent_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_valid) begin
				wptr_q <= (wptr_q == BUF_PTR_W'(BUF_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == BUF_PTR_W'(BUF_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({wr_valid, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == BUF_CNT_W'(BUF_DEPTH)) |-> !(wr_valid && !pop))
		else $error("result buffer overflow");

	a_space_holds_off: assert property (@(posedge clk) disable iff (!arst_n)
		(!space && !pop) |=> (cnt_q != '0))
		else $error("input held off while the buffer drained");
`endif

endmodule

// File: src/grayscale_row_mirror.sv
// ----------------------------------------------------------------------------
// grayscale_row_mirror
// RGB to grayscale with a left-to-right mirror of the previous row.
//
//  Channel  Dir  Handshake                  Payload
//  s_axis   in   s_axis_tvalid/tready       tdata: red, green, blue; tuser: cmd
//  m_axis   out  m_axis_tvalid/tready       tdata: gray, mirror; tuser: flags;
//                                           tlast: mirror_row_end
//  cfg      in   cfg_wen                    cfg_wdata: row_width
//
// One transfer is accepted per clock while s_axis_tready is high.
// The luma and the line store write happen in the accept cycle, and the
// mirrored read from the other bank is registered in the same cycle.
// Reset clears the row counters and the buffer; the line store is not cleared.
// A three-entry result buffer absorbs output stalls; s_axis_tready drops
// when it and the stage in flight would fill it.
// ----------------------------------------------------------------------------
module grayscale_row_mirror #(
	parameter int MAX_WIDTH = grm_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wen,
	input  logic [grm_pkg::RW_W-1:0] cfg_wdata,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [23:0]              s_axis_tdata,  // red, green, blue
	input  logic                     s_axis_tuser,  // cmd
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [15:0]              m_axis_tdata,  // gray_value, mirror_value
	output logic [1:0]               m_axis_tuser,  // gray_valid, mirror_valid
	output logic                     m_axis_tlast
);
	import grm_pkg::*;

	logic space;
	logic res_valid;
	res_t res;
	res_t out_data;

	grm_row_core #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_axis_tvalid),
		.space    (space),
		.cmd      (s_axis_tuser),
		.red      (s_axis_tdata[7:0]),
		.green    (s_axis_tdata[15:8]),
		.blue     (s_axis_tdata[23:16]),
		.res_valid(res_valid),
		.res      (res)
	);

	grm_out_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (res_valid),
		.wr_data  (res),
		.space    (space),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (out_data)
	);

	assign s_axis_tready = space;
	assign m_axis_tdata  = {out_data.mirror_value, out_data.gray_value};
	assign m_axis_tuser  = {out_data.mirror_valid, out_data.gray_valid};
	assign m_axis_tlast  = out_data.mirror_row_end;

endmodule

// File: bench/luma_mirror_scoreboard.sv
// ----------------------------------------------------------------------------
// luma_mirror_scoreboard
// Watches the pixel and result channels of grayscale_row_mirror. It predicts
// the luma and the mirrored previous-row pixel for every accepted pixel or
// flush transfer, and compares every accepted result, field by field, in order.
// ----------------------------------------------------------------------------
module luma_mirror_scoreboard
	import grm_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wen,
	input  logic [RW_W-1:0] cfg_wdata,
	input  logic            s_axis_tvalid,
	input  logic            s_axis_tready,
	input  logic [23:0]     s_axis_tdata,  // red, green, blue
	input  logic            s_axis_tuser,  // cmd
	input  logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	input  logic [15:0]     m_axis_tdata,  // gray_value, mirror_value
	input  logic [1:0]      m_axis_tuser,  // gray_valid, mirror_valid
	input  logic            m_axis_tlast,
	output int              outstanding,
	output int              errors
);

	localparam int WEIGHT_R = 54;
	localparam int WEIGHT_G = 184;
	localparam int WEIGHT_B = 18;

	logic [PIX_W-1:0] gray_rows [2][MAX_WIDTH];
	logic [RW_W-1:0]  row_width;
	int               column;
	logic             write_bank;
	logic             row_ready;
	res_t             pending_results [$];

	function automatic res_t predict_transfer(input cmd_t kind, input logic [23:0] rgb);
		res_t res;
		int   width;
		int   mirror_col;
		int   weighted;
		bit   row_end;
		width = row_width;
		if (width < 1) width = 1;
		if (width > MAX_WIDTH) width = MAX_WIDTH;
		row_end = (column + 1 >= width);
		res = '0;
		if (row_ready) begin
			mirror_col = (column < width) ? width - 1 - column : 0;
			res.mirror_valid = 1'b1;
			res.mirror_value = gray_rows[!write_bank][mirror_col];
			res.mirror_row_end = row_end;
		end
		if (kind == CMD_PIXEL) begin
			weighted = WEIGHT_R * rgb[7:0] + WEIGHT_G * rgb[15:8] + WEIGHT_B * rgb[23:16];
			res.gray_valid = 1'b1;
			res.gray_value = weighted[15:8];
			gray_rows[write_bank][column] = res.gray_value;
		end
		if (row_end) begin
			column = 0;
			if (kind == CMD_PIXEL) begin
				write_bank = !write_bank;
				row_ready = 1'b1;
			end else begin
				row_ready = 1'b0;
			end
		end else begin
			column++;
		end
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [PIX_W-1:0] want,
			input logic [PIX_W-1:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			pending_results.delete();
			column = 0;
			write_bank = 1'b0;
			row_ready = 1'b0;
			row_width = RW_W'(ROW_WIDTH_RST);
			outstanding <= 0;
		end else begin
			if (cfg_wen) row_width = cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with no pixel transfer pending");
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("gray_valid", PIX_W'(want.gray_valid),
						PIX_W'(m_axis_tuser[0]));
					check_field("gray_value", want.gray_value, m_axis_tdata[7:0]);
					check_field("mirror_valid", PIX_W'(want.mirror_valid),
						PIX_W'(m_axis_tuser[1]));
					check_field("mirror_value", want.mirror_value, m_axis_tdata[15:8]);
					check_field("mirror_row_end", PIX_W'(want.mirror_row_end),
						PIX_W'(m_axis_tlast));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_results.push_back(predict_transfer(cmd_t'(s_axis_tuser), s_axis_tdata));
			outstanding <= pending_results.size();
		end
	end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for grayscale_row_mirror: corner colors, a long receiver hold-off,
// flushes with and without a stored row, width changes within a row, the widest
// and clamped widths, then random rows under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import grm_pkg::*;

	localparam int HOLD_CYCLES  = 200;
	localparam int QUIET_LIMIT  = 3000;
	localparam int RANDOM_ITEMS = 180;
	localparam int FILL_WIDTH   = 48;
	localparam int START_PIXELS = 40;
	localparam logic [23:0] CORNER_RGB [8] = '{
		24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
		24'hFF0000, 24'hAA55AA, 24'h55AA55, 24'h7F807F
	};

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_wen = 1'b0;
	logic [RW_W-1:0] cfg_wdata = '0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	logic [23:0]     s_axis_tdata = '0;  // red, green, blue
	logic            s_axis_tuser = 1'b0;  // cmd
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	logic [15:0]     m_axis_tdata;  // gray_value, mirror_value
	logic [1:0]      m_axis_tuser;  // gray_valid, mirror_valid
	logic            m_axis_tlast;
	int              outstanding;
	int              errors;

	int sender_idle = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int row_len = ROW_WIDTH_RST;
	int row_col = 0;
	bit row_stored = 1'b0;

	always #1 clk = ~clk;

	grayscale_row_mirror dut (.*);

	luma_mirror_scoreboard scoreboard (.*);

	function automatic int clamp_width(input logic [RW_W-1:0] value);
		if (value < 1) return 1;
		if (value > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return value;
	endfunction

	// Random widths never exceed the fill width, so every mirrored read lands
	// on an entry that the startup rows have filled in both banks.
	function automatic logic [RW_W-1:0] pick_width();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5) return '0;
		if (roll < 12) return RW_W'(1);
		if (roll < 90) return RW_W'($urandom_range(16, 2));
		if (roll < 97) return RW_W'($urandom_range(32, 17));
		return RW_W'($urandom_range(FILL_WIDTH, 33));
	endfunction

	task automatic send_item(input cmd_t kind, input logic [23:0] rgb);
		while ($urandom_range(99) < sender_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= rgb;
		do @(posedge clk); while (!s_axis_tready);
		if (row_col + 1 >= row_len) begin
			row_col = 0;
			row_stored = (kind == CMD_PIXEL);
		end else begin
			row_col++;
		end
	endtask

	task automatic send_random(input cmd_t kind);
		send_item(kind, 24'($urandom));
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_width(input logic [RW_W-1:0] value);
		settle();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		row_len = clamp_width(value);
	endtask

	task automatic drain_row();
		while (row_stored || row_col != 0) send_random(CMD_FLUSH);
	endtask

	task automatic random_phase(input int idle_pct, input int stall);
		int flush_left;
		sender_idle = idle_pct;
		stall_pct = stall;
		flush_left = 0;
		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(49) == 0) set_width(pick_width());
			else if ($urandom_range(59) == 0) settle();
			if (flush_left == 0 && $urandom_range(29) == 0)
				flush_left = $urandom_range(row_len + 2, 1);
			if (flush_left > 0) begin
				flush_left--;
				send_random(CMD_FLUSH);
			end else begin
				send_random(($urandom_range(19) == 0) ? CMD_FLUSH : CMD_PIXEL);
			end
		end
	endtask

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A partial row at the reset width is finished at the fill width, and a
		// second row fills the other bank while the first row is mirrored.
		foreach (CORNER_RGB[i]) send_item(CMD_PIXEL, CORNER_RGB[i]);
		repeat (START_PIXELS - $size(CORNER_RGB)) send_random(CMD_PIXEL);
		set_width(RW_W'(FILL_WIDTH));
		repeat (2 * FILL_WIDTH - START_PIXELS) send_random(CMD_PIXEL);

		hold_requests++;
		repeat (40) send_random(CMD_PIXEL);
		drain_row();

		set_width(5);
		repeat (2) send_random(CMD_FLUSH);
		repeat (8) send_random(CMD_PIXEL);
		repeat (5) send_random(CMD_FLUSH);
		set_width(1);
		repeat (2) send_random(CMD_PIXEL);
		send_random(CMD_FLUSH);
		set_width(0);
		repeat (2) send_random(CMD_PIXEL);

		// The width shrinks below the current column while a row is stored.
		set_width(10);
		repeat (16) send_random(CMD_PIXEL);
		set_width(4);
		repeat (3) send_random(CMD_PIXEL);

		// Clamped and widest widths must not end a row early.
		drain_row();
		set_width('1);
		repeat (20) send_random(CMD_PIXEL);
		set_width(RW_W'(MAX_WIDTH_DEF));
		repeat (20) send_random(CMD_PIXEL);
		set_width(3);
		repeat (6) send_random(CMD_PIXEL);

		random_phase(0, 0);
		random_phase(65, 0);
		random_phase(0, 65);
		random_phase(34, 34);

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
